// ===== hdl/rpnee_pkg.sv =====
// Shared types and constants for the RPN expression evaluator.
// Holds ALU op codes, ALU request/response structs, status and character codes.
// No dependencies.
package rpnee_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_DIVZERO   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // expression characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

endpackage

// ===== hdl/rpn_expression_evaluator_unit.sv =====
// Postfix (RPN) integer expression evaluator, top level: sequencer and operand stack.
// Depends on rpnee_pkg and rpnee_alu.
// Sequencing: digit, space and ignored characters are handled in the idle state; +, -, * and /
// pass through S_TOP, S_BOT and S_EXEC, where * and / wait on the bit-per-cycle loop of rpnee_alu.
// Terminator: enters S_FIN, which registers the result; S_FIN waits while an earlier result is untaken.
// Throughput: one transaction at a time; ch_ready is high only while the sequencer idles.
// Reset: synchronous active-high rst clears control state; stack RAM is not cleared.
module rpn_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ch_valid,
  output logic               ch_ready,
  input  logic [7:0]         ch,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] value,
  output logic [1:0]         status
);

  localparam int SPW = $clog2(STACK_DEPTH);
  localparam logic [SPW:0] DEPTH_W = (SPW + 1)'(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TOP  = 5'b00010,  // read data holds top operand
    S_BOT  = 5'b00100,  // read data holds bottom operand, ALU start
    S_EXEC = 5'b01000,
    S_FIN  = 5'b10000   // emit result and clear
  } state_t;

  // Closed entries live in the RAM at 0..sp-1. The open slot (index sp) is
  // kept in the top register, so every RAM read hits an entry written
  // during the current expression and no clearing pass is needed.
  state_t                state;
  logic [SPW-1:0]        sp;
  logic [31:0]           top;
  logic                  digit_seen;
  logic [1:0]            err;
  rpnee_pkg::alu_op_t    op;
  logic [31:0]           top_opnd;

  logic [31:0]           mem [STACK_DEPTH];
  logic [31:0]           rd_data;
  logic [SPW-1:0]        rd_addr;
  logic [SPW-1:0]        wr_addr;
  logic [31:0]           wr_data;
  logic                  we;

  rpnee_pkg::alu_req_t   alu_req;
  rpnee_pkg::alu_rsp_t   alu_rsp;
  rpnee_pkg::alu_op_t    op_code;

  logic                  accept;
  logic                  live;
  logic                  is_digit;
  logic                  is_op;
  logic                  is_space;
  logic                  sp_lt2;
  logic                  push_full;
  logic [31:0]           top_fold;

  assign ch_ready  = (state == S_IDLE);
  assign accept    = ch_valid & ch_ready;
  // a character that acts on the stack: not the terminator and no error pending
  assign live      = accept && (ch != rpnee_pkg::CH_NUL) && (err == rpnee_pkg::ST_OK);
  assign is_digit  = (ch >= rpnee_pkg::CH_0) && (ch <= rpnee_pkg::CH_9);
  assign is_op     = (ch == rpnee_pkg::CH_PLUS) || (ch == rpnee_pkg::CH_MINUS) ||
                     (ch == rpnee_pkg::CH_STAR) || (ch == rpnee_pkg::CH_SLASH);
  assign is_space  = (ch == rpnee_pkg::CH_SPACE);
  assign sp_lt2    = (sp < SPW'(2));
  assign push_full = (({1'b0, sp} + 1'b1) >= DEPTH_W);

  // top*10 + digit as two shifted adds, 32-bit wrap
  assign top_fold = {top[28:0], 3'b000} + {top[30:0], 1'b0} +
                    {24'b0, ch - rpnee_pkg::CH_0};

  always_comb begin
    unique case (ch)
      rpnee_pkg::CH_PLUS:  op_code = rpnee_pkg::OP_ADD;
      rpnee_pkg::CH_MINUS: op_code = rpnee_pkg::OP_SUB;
      rpnee_pkg::CH_STAR:  op_code = rpnee_pkg::OP_MUL;
      default:             op_code = rpnee_pkg::OP_DIV;
    endcase
  end

  // RAM port control
  always_comb begin
    we      = 1'b0;
    wr_addr = sp;
    wr_data = top;
    rd_addr = '0;   // terminator path reads entry 0
    unique case (state)
      S_IDLE: begin
        if (live && is_op && !sp_lt2) rd_addr = sp - SPW'(1);
        if (live && !is_digit && !is_op && is_space && digit_seen && !push_full) we = 1'b1;
      end
      S_TOP: rd_addr = sp - SPW'(2);
      S_EXEC: begin
        if (alu_rsp.done) begin
          we      = 1'b1;
          wr_addr = sp - SPW'(2);
          wr_data = alu_rsp.result;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign alu_req.start = (state == S_BOT);
  assign alu_req.op    = op;

  rpnee_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (rd_data),
    .b   (top_opnd),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sp           <= '0;
      top          <= '0;
      digit_seen   <= 1'b0;
      err          <= rpnee_pkg::ST_OK;
      result_valid <= 1'b0;
    end else begin
      // output register: loads from the result state, drops once taken
      if (state == S_FIN && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && ch == rpnee_pkg::CH_NUL) begin
            state <= S_FIN;
          end else if (live) begin
            if (is_digit) begin
              top        <= top_fold;
              digit_seen <= 1'b1;
            end else if (is_op) begin
              digit_seen <= 1'b0;
              if (sp_lt2) begin
                err <= rpnee_pkg::ST_UNDERFLOW;
              end else begin
                op    <= op_code;
                state <= S_TOP;
              end
            end else if (is_space && digit_seen) begin
              digit_seen <= 1'b0;
              if (push_full) begin
                err <= rpnee_pkg::ST_OVERFLOW;
              end else begin
                sp  <= sp + SPW'(1);
                top <= '0;
              end
            end
          end
        end
        S_TOP: begin
          top_opnd <= rd_data;
          if (op == rpnee_pkg::OP_DIV && rd_data == 32'd0) begin
            err   <= rpnee_pkg::ST_DIVZERO;
            state <= S_IDLE;
          end else begin
            state <= S_BOT;
          end
        end
        S_BOT: state <= S_EXEC;
        S_EXEC: begin
          if (alu_rsp.done) begin
            sp    <= sp - SPW'(1);
            top   <= '0;
            state <= S_IDLE;
          end
        end
        S_FIN: begin
          if (!result_valid || result_ready) begin
            if (err != rpnee_pkg::ST_OK) value <= '0;
            else if (sp == '0)           value <= top;
            else                         value <= rd_data;
            status     <= err;
            sp         <= '0;
            top        <= '0;
            digit_seen <= 1'b0;
            err        <= rpnee_pkg::ST_OK;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_term_to_fin: assert property (@(posedge clk) disable iff (rst)
    (accept && ch == rpnee_pkg::CH_NUL) |=> (state == S_FIN))
    else $error("terminator did not enter result state");

  a_alu_done_exec: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == S_EXEC))
    else $error("ALU completion outside execute state");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!result_valid || result_ready)) |=>
      (result_valid && sp == '0 && err == rpnee_pkg::ST_OK && !digit_seen))
    else $error("result emission did not clear expression state");

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, sp} < DEPTH_W))
    else $error("stack pointer beyond depth");

  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    (err != rpnee_pkg::ST_OK) |-> !we)
    else $error("stack write while an error is pending");
`endif

endmodule

// ===== hdl/rpnee_alu.sv =====
// Iterative 32-bit ALU: add, sub, shift-add multiply, signed restoring divide.
// One 33-bit adder is shared by every operation and step.
// Depends on rpnee_pkg.
module rpnee_alu (
  input  logic                clk,
  input  logic                rst,
  input  rpnee_pkg::alu_req_t req,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output rpnee_pkg::alu_rsp_t rsp
);

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_ABSA = 6'b000010,
    A_ABSB = 6'b000100,
    A_MUL  = 6'b001000,
    A_DIV  = 6'b010000,
    A_FIX  = 6'b100000
  } alu_state_t;

  localparam logic [4:0] LAST_STEP = 5'd31;

  alu_state_t  state;
  logic [32:0] acc;    // product / partial remainder
  logic [31:0] x;      // multiplicand / dividend then quotient
  logic [31:0] y;      // multiplier / divisor
  logic [4:0]  cnt;
  logic        neg;
  logic        done;
  logic [31:0] res;

  logic [32:0] add_l;
  logic [32:0] add_r;
  logic        add_cin;
  logic [32:0] sum;

  assign sum = add_l + add_r + {32'b0, add_cin};

  always_comb begin
    add_l   = '0;
    add_r   = '0;
    add_cin = 1'b0;
    unique case (state)
      A_IDLE: begin
        add_l   = {1'b0, a};
        add_r   = (req.op == rpnee_pkg::OP_SUB) ? {1'b0, ~b} : {1'b0, b};
        add_cin = (req.op == rpnee_pkg::OP_SUB);
      end
      A_ABSA: begin
        add_r   = {1'b0, ~x};
        add_cin = 1'b1;
      end
      A_ABSB: begin
        add_r   = {1'b0, ~y};
        add_cin = 1'b1;
      end
      A_MUL: begin
        add_l = acc;
        add_r = y[0] ? {1'b0, x} : '0;
      end
      A_DIV: begin
        // trial subtract of divisor from shifted remainder
        add_l   = {acc[31:0], x[31]};
        add_r   = {1'b1, ~y};
        add_cin = 1'b1;
      end
      A_FIX: begin
        add_r   = {1'b0, ~x};
        add_cin = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            unique case (req.op) inside
              rpnee_pkg::OP_ADD, rpnee_pkg::OP_SUB: begin
                res  <= sum[31:0];
                done <= 1'b1;
              end
              rpnee_pkg::OP_MUL: begin
                acc   <= '0;
                x     <= a;
                y     <= b;
                cnt   <= '0;
                state <= A_MUL;
              end
              rpnee_pkg::OP_DIV: begin
                acc   <= '0;
                x     <= a;
                y     <= b;
                neg   <= a[31] ^ b[31];
                cnt   <= '0;
                state <= A_ABSA;
              end
              default: ;
            endcase
          end
        end
        A_ABSA: begin
          if (x[31]) x <= sum[31:0];
          state <= A_ABSB;
        end
        A_ABSB: begin
          if (y[31]) y <= sum[31:0];
          state <= A_DIV;
        end
        A_MUL: begin
          if (y[0]) acc <= {1'b0, sum[31:0]};
          x   <= {x[30:0], 1'b0};
          y   <= {1'b0, y[31:1]};
          cnt <= cnt + 5'd1;
          if (cnt == LAST_STEP) begin
            res   <= y[0] ? sum[31:0] : acc[31:0];
            done  <= 1'b1;
            state <= A_IDLE;
          end
        end
        A_DIV: begin
          acc <= sum[32] ? add_l : sum;
          x   <= {x[30:0], ~sum[32]};
          cnt <= cnt + 5'd1;
          if (cnt == LAST_STEP) state <= A_FIX;
        end
        A_FIX: begin
          // quotient sign; most negative / -1 wraps naturally
          res   <= neg ? sum[31:0] : x;
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = res;

endmodule
